// ----- hw/rtl/qsrp_pkg.sv -----
// Package: types, constants and hash helpers for the quoted string record parser.
package qsrp_pkg;

   localparam logic [31:0] FNV_PRIME = 32'h0100_0193;
   localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;

   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   localparam logic [15:0] LEN_MAX = 16'hFFFF;

   typedef enum logic [2:0] {
      PH_SKIP = 3'd0,
      PH_ID   = 3'd1,
      PH_SEP  = 3'd2,
      PH_TEXT = 3'd3,
      PH_ESC  = 3'd4
   } phase_type;

   localparam logic [1:0] KIND_TEXT  = 2'd0;
   localparam logic [1:0] KIND_DONE  = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam logic [2:0] ERR_NO_HASH     = 3'd0;
   localparam logic [2:0] ERR_NO_TEXT     = 3'd1;
   localparam logic [2:0] ERR_BAD_SEP     = 3'd2;
   localparam logic [2:0] ERR_OPEN_TEXT   = 3'd3;
   localparam logic [2:0] ERR_OPEN_ESCAPE = 3'd4;
   localparam logic [2:0] ERR_BAD_ESCAPE  = 3'd5;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  text_byte;
      logic [31:0] id_hash;
      logic [15:0] text_length;
      logic [2:0]  error_code;
      logic        last_result;
   } rsp_type;

   function automatic logic [31:0] fnv_fold(logic [31:0] h, logic [7:0] c);
      logic [7:0] lc;
      lc = c;
      if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
         lc = c + CASE_OFFSET;
      end
      return (h ^ {24'd0, lc}) * FNV_PRIME;
   endfunction

   function automatic logic [31:0] swap32(logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

endpackage

// ----- hw/rtl/qsrp_if.sv -----
// Interfaces: the byte request channel and the result channel.
interface qsrp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_input;

   modport source (output valid, output in_byte, output end_of_input, input ready);
   modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface qsrp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  text_byte;
   logic [31:0] id_hash;
   logic [15:0] text_length;
   logic [2:0]  error_code;
   logic        last_result;

   modport source (output valid, output kind, output text_byte, output id_hash,
                   output text_length, output error_code, output last_result,
                   input ready);
   modport sink (input valid, input kind, input text_byte, input id_hash,
                 input text_length, input error_code, input last_result,
                 output ready);
endinterface

// ----- hw/rtl/quoted_string_record_parser_top.sv -----
// Top level: byte-wise quoted string record parser with a small result queue.
//
// Usage: one byte per request arrives on req_if (in_byte, end_of_input); results
// leave on rsp_if as text bytes, record-done entries (byte-swapped FNV-1a hash
// of the identifier and saturated text length) or errors, the last result of a
// request carrying last_result.
// A request is decoded in the cycle it is accepted: parser state updates at that
// edge and its results are written into a four-entry result queue, so the first
// result is in the queue from the following cycle, behind any results waiting.
// Throughput is one request per cycle while req_if.ready is high. A request
// yields at most two results (a text byte followed by an error, only on the
// final byte); the result port drains one per cycle while rsp_if.ready is high.
// req_if.ready is high while the queue has room for two results; when the
// receiver stalls, the queue fills and ready drops once three or more results
// are waiting, which takes at most three requests that yield results.
// A synchronous reset empties the queue and returns the parser to skipping
// whitespace with a fresh hash; the final byte does so for the parser only.
module quoted_string_record_parser_top (
   input logic clock,
   input logic reset,
   qsrp_req_if.sink   req_if,
   qsrp_rsp_if.source rsp_if
);
   import qsrp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [31:0] hash_ff, hash_in;
   logic [15:0] len_ff, len_in;
   logic        halted_ff, halted_in;

   rsp_type              q_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   cnt_ff, cnt_in;

   logic [7:0]  c;
   logic        last;
   logic        accept, pop;
   logic        is_small, is_id_char, is_sep_char, is_quote, is_bslash;
   logic        esc_ok;
   logic [7:0]  esc_val;
   logic        emit_text, emit_done, err_v;
   logic [7:0]  text_val;
   logic [2:0]  err_c;
   logic [1:0]  push_n;
   logic [15:0] len_inc;
   rsp_type     r0, r1;

   assign c      = req_if.in_byte;
   assign last   = req_if.end_of_input;
   assign accept = req_if.valid && req_if.ready;
   assign pop    = rsp_if.valid && rsp_if.ready;

   assign is_small    = c[7] || (c <= CH_SPACE);
   assign is_quote    = (c == CH_QUOTE);
   assign is_bslash   = (c == CH_BSLASH);
   assign is_sep_char = (c == CH_COMMA) || (c == CH_SPACE) || (c == CH_TAB);
   assign is_id_char  = !is_small && (c != CH_COMMA) && !is_quote;
   assign len_inc     = (len_ff == LEN_MAX) ? len_ff : len_ff + 16'd1;

   always_comb begin
      esc_ok  = 1'b1;
      esc_val = 8'd0;
      case (c)
         CH_N:      esc_val = CH_LF;
         CH_R:      esc_val = CH_CR;
         CH_BSLASH: esc_val = CH_BSLASH;
         CH_QUOTE:  esc_val = CH_QUOTE;
         CH_T:      esc_val = CH_TAB;
         default:   esc_ok  = 1'b0;
      endcase
   end

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (last) begin
         phase_in = PH_SKIP;
      end else if (!halted_ff) begin
         case (phase_ff)
            PH_ID: begin
               if (!is_id_char) begin
                  phase_in = is_quote ? PH_TEXT : PH_SEP;
               end
            end
            PH_SEP: begin
               if (is_quote) begin
                  phase_in = PH_TEXT;
               end
            end
            PH_TEXT: begin
               if (is_quote) begin
                  phase_in = PH_SKIP;
               end else if (is_bslash) begin
                  phase_in = PH_ESC;
               end
            end
            PH_ESC: begin
               if (esc_ok) begin
                  phase_in = PH_TEXT;
               end
            end
            default: begin
               if (!is_small && c == CH_HASH) begin
                  phase_in = PH_ID;
               end
            end
         endcase
      end
   end

   // Results and datapath state.
   always_comb begin
      emit_text = 1'b0;
      emit_done = 1'b0;
      err_v     = 1'b0;
      err_c     = ERR_NO_HASH;
      text_val  = c;
      hash_in   = hash_ff;
      len_in    = len_ff;
      halted_in = halted_ff;
      if (!halted_ff) begin
         case (phase_ff)
            PH_ID, PH_SEP: begin
               if (phase_ff == PH_ID && is_id_char) begin
                  hash_in = fnv_fold(hash_ff, c);
                  if (last) begin
                     err_v = 1'b1;
                     err_c = ERR_NO_TEXT;
                  end
               end else if (is_sep_char) begin
                  if (last) begin
                     err_v = 1'b1;
                     err_c = ERR_NO_TEXT;
                  end
               end else if (is_quote) begin
                  len_in = 16'd0;
                  if (last) begin
                     err_v = 1'b1;
                     err_c = ERR_OPEN_TEXT;
                  end
               end else begin
                  err_v = 1'b1;
                  err_c = ERR_BAD_SEP;
               end
            end
            PH_TEXT: begin
               if (is_quote) begin
                  emit_done = 1'b1;
                  hash_in   = FNV_BASIS;
                  len_in    = 16'd0;
               end else if (is_bslash) begin
                  if (last) begin
                     err_v = 1'b1;
                     err_c = ERR_OPEN_ESCAPE;
                  end
               end else begin
                  emit_text = 1'b1;
                  len_in    = len_inc;
                  if (last) begin
                     err_v = 1'b1;
                     err_c = ERR_OPEN_TEXT;
                  end
               end
            end
            PH_ESC: begin
               if (!esc_ok) begin
                  err_v = 1'b1;
                  err_c = ERR_BAD_ESCAPE;
               end else begin
                  emit_text = 1'b1;
                  text_val  = esc_val;
                  len_in    = len_inc;
                  if (last) begin
                     err_v = 1'b1;
                     err_c = ERR_OPEN_TEXT;
                  end
               end
            end
            default: begin
               if (!is_small) begin
                  if (c != CH_HASH) begin
                     err_v = 1'b1;
                     err_c = ERR_NO_HASH;
                  end else begin
                     hash_in = fnv_fold(FNV_BASIS, c);
                     if (last) begin
                        err_v = 1'b1;
                        err_c = ERR_NO_TEXT;
                     end
                  end
               end
            end
         endcase
         if (err_v) begin
            halted_in = 1'b1;
         end
      end
      if (last) begin
         hash_in   = FNV_BASIS;
         len_in    = 16'd0;
         halted_in = 1'b0;
      end
   end

   // Results of the current request, in order.
   always_comb begin
      r0 = '0;
      r1 = '0;
      if (emit_text) begin
         r0.kind      = KIND_TEXT;
         r0.text_byte = text_val;
      end else if (emit_done) begin
         r0.kind        = KIND_DONE;
         r0.id_hash     = swap32(hash_ff);
         r0.text_length = len_ff;
      end else begin
         r0.kind       = KIND_ERROR;
         r0.error_code = err_c;
      end
      r0.last_result = !(emit_text && err_v);
      r1.kind        = KIND_ERROR;
      r1.error_code  = err_c;
      r1.last_result = 1'b1;
      if (!accept) begin
         push_n = 2'd0;
      end else begin
         push_n = {1'b0, emit_text || emit_done || err_v} + {1'b0, emit_text && err_v};
      end
   end

   assign wr_ptr_in = wr_ptr_ff + push_n[Q_PTR_W-1:0];
   assign rd_ptr_in = pop ? rd_ptr_ff + Q_PTR_W'(1) : rd_ptr_ff;
   assign cnt_in    = cnt_ff + Q_CNT_W'(push_n) - Q_CNT_W'(pop);

   assign req_if.ready = (cnt_ff <= Q_CNT_W'(Q_DEPTH - 2));
   assign rsp_if.valid = (cnt_ff != '0);

   assign rsp_if.kind        = q_ff[rd_ptr_ff].kind;
   assign rsp_if.text_byte   = q_ff[rd_ptr_ff].text_byte;
   assign rsp_if.id_hash     = q_ff[rd_ptr_ff].id_hash;
   assign rsp_if.text_length = q_ff[rd_ptr_ff].text_length;
   assign rsp_if.error_code  = q_ff[rd_ptr_ff].error_code;
   assign rsp_if.last_result = q_ff[rd_ptr_ff].last_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SKIP;
         hash_ff   <= FNV_BASIS;
         len_ff    <= 16'd0;
         halted_ff <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (accept) begin
            phase_ff  <= phase_in;
            hash_ff   <= hash_in;
            len_ff    <= len_in;
            halted_ff <= halted_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         q_ff[wr_ptr_ff] <= r0;
      end
      if (push_n == 2'd2) begin
         q_ff[wr_ptr_ff + Q_PTR_W'(1)] <= r1;
      end
   end

`ifndef SYNTH
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= Q_CNT_W'(Q_DEPTH))
      else $error("result queue count out of range");

   a_final_resets: assert property (@(posedge clock) disable iff (reset)
      accept && last |=> phase_ff == PH_SKIP && !halted_ff && hash_ff == FNV_BASIS
         && len_ff == 16'd0)
      else $error("parser state not restored after final byte");

   a_pair_is_text_error: assert property (@(posedge clock) disable iff (reset)
      push_n == 2'd2 |-> emit_text && err_v && last)
      else $error("two results pushed without text byte and error on final byte");

   a_halted_silent: assert property (@(posedge clock) disable iff (reset)
      accept && halted_ff |-> push_n == 2'd0)
      else $error("halted parser produced a result");
`endif

endmodule

// ----- dv/qsrp_record_checker.sv -----
// Checker: predicts the parser's results from each accepted request and compares them.
module qsrp_record_checker (
   input  logic clock,
   input  logic reset,
   qsrp_req_if  req_mon,
   qsrp_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending,
   output int   results_checked,
   output int   records_done,
   output int   errors_seen
);
   timeunit 1ns;
   timeprecision 1ps;
   import qsrp_pkg::*;

   phase_type   parse_phase;
   logic [31:0] id_hash_acc;
   logic [15:0] text_len;
   logic        halted;
   int          step_results;
   rsp_type     expected_q[$];

   function automatic logic [31:0] hash_step(logic [31:0] h, logic [7:0] c);
      logic [7:0] folded;
      folded = c;
      if (c >= "A" && c <= "Z") begin
         folded = c + 8'd32;
      end
      return (h ^ {24'd0, folded}) * FNV_PRIME;
   endfunction

   function automatic logic [31:0] byte_swap(logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

   function automatic void clear_state();
      parse_phase = PH_SKIP;
      id_hash_acc = FNV_BASIS;
      text_len = 16'd0;
      halted = 1'b0;
   endfunction

   function automatic void push_result(logic [1:0] kind, logic [7:0] tb, logic [31:0] h,
                                       logic [15:0] len, logic [2:0] err);
      rsp_type r;
      r.kind = kind;
      r.text_byte = tb;
      r.id_hash = h;
      r.text_length = len;
      r.error_code = err;
      r.last_result = 1'b0;
      expected_q = {expected_q, r};
      step_results++;
   endfunction

   function automatic void add_text(logic [7:0] c);
      push_result(KIND_TEXT, c, 32'd0, 16'd0, 3'd0);
      if (text_len != LEN_MAX) begin
         text_len = text_len + 16'd1;
      end
   endfunction

   function automatic int take_separator(logic [7:0] c, logic last);
      if (c == CH_COMMA || c == CH_SPACE || c == CH_TAB) begin
         return last ? int'(ERR_NO_TEXT) : -1;
      end
      if (c == CH_QUOTE) begin
         parse_phase = PH_TEXT;
         text_len = 16'd0;
         return last ? int'(ERR_OPEN_TEXT) : -1;
      end
      return int'(ERR_BAD_SEP);
   endfunction

   task automatic parse_byte(input logic [7:0] c, input logic last);
      int      code;
      logic    blank;
      code = -1;
      step_results = 0;
      blank = c[7] || (c <= CH_SPACE);
      if (!halted) begin
         case (parse_phase)
            PH_ID: begin
               if (!blank && c != CH_COMMA && c != CH_QUOTE) begin
                  id_hash_acc = hash_step(id_hash_acc, c);
                  if (last) code = int'(ERR_NO_TEXT);
               end else begin
                  parse_phase = PH_SEP;
                  code = take_separator(c, last);
               end
            end
            PH_SEP: begin
               code = take_separator(c, last);
            end
            PH_TEXT: begin
               if (c == CH_QUOTE) begin
                  push_result(KIND_DONE, 8'd0, byte_swap(id_hash_acc), text_len, 3'd0);
                  parse_phase = PH_SKIP;
                  id_hash_acc = FNV_BASIS;
                  text_len = 16'd0;
               end else if (c == CH_BSLASH) begin
                  parse_phase = PH_ESC;
                  if (last) code = int'(ERR_OPEN_ESCAPE);
               end else begin
                  add_text(c);
                  if (last) code = int'(ERR_OPEN_TEXT);
               end
            end
            PH_ESC: begin
               case (c)
                  CH_N:      add_text(CH_LF);
                  CH_R:      add_text(CH_CR);
                  CH_BSLASH: add_text(CH_BSLASH);
                  CH_QUOTE:  add_text(CH_QUOTE);
                  CH_T:      add_text(CH_TAB);
                  default:   code = int'(ERR_BAD_ESCAPE);
               endcase
               if (code < 0) begin
                  parse_phase = PH_TEXT;
                  if (last) code = int'(ERR_OPEN_TEXT);
               end
            end
            default: begin
               if (!blank) begin
                  if (c != CH_HASH) begin
                     code = int'(ERR_NO_HASH);
                  end else begin
                     id_hash_acc = hash_step(FNV_BASIS, c);
                     parse_phase = PH_ID;
                     if (last) code = int'(ERR_NO_TEXT);
                  end
               end
            end
         endcase
         if (code >= 0) begin
            push_result(KIND_ERROR, 8'd0, 32'd0, 16'd0, code[2:0]);
            halted = 1'b1;
         end
      end
      if (last) clear_state();
      if (step_results > 0) begin
         expected_q[expected_q.size() - 1].last_result = 1'b1;
      end
   endtask

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   task automatic compare_result();
      rsp_type want;
      results_checked++;
      if (expected_q.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual kind %0d byte %0h hash %0h",
                  $time, rsp_mon.kind, rsp_mon.text_byte, rsp_mon.id_hash);
         $display("%0t: unexpected result, actual len %0d err %0d last %b",
                  $time, rsp_mon.text_length, rsp_mon.error_code, rsp_mon.last_result);
         fail_count++;
      end else begin
         want = expected_q.pop_front();
         check_field("kind", 32'(want.kind), 32'(rsp_mon.kind));
         check_field("text_byte", 32'(want.text_byte), 32'(rsp_mon.text_byte));
         check_field("id_hash", want.id_hash, rsp_mon.id_hash);
         check_field("text_length", 32'(want.text_length), 32'(rsp_mon.text_length));
         check_field("error_code", 32'(want.error_code), 32'(rsp_mon.error_code));
         check_field("last_result", 32'(want.last_result), 32'(rsp_mon.last_result));
         if (want.kind == KIND_DONE) records_done++;
         if (want.kind == KIND_ERROR) errors_seen++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_state();
         expected_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            compare_result();
         end
         if (req_mon.valid && req_mon.ready) begin
            parse_byte(req_mon.in_byte, req_mon.end_of_input);
         end
      end
      pending = expected_q.size();
   end

endmodule

// ----- dv/quoted_string_record_parser_top_tb.sv -----
// Testbench top: clock, reset, byte stimulus, result stalls, watchdog and verdict.
module quoted_string_record_parser_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import qsrp_pkg::*;

   localparam int RANDOM_ITEMS   = 400;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;

   logic clock;
   logic reset;
   bit   idle_on;
   bit   stall_on;
   int   stall_left;
   int   requests_sent;
   int   fail_count;
   int   pending;
   int   results_checked;
   int   records_done;
   int   errors_seen;

   qsrp_req_if req_if();
   qsrp_rsp_if rsp_if();

   quoted_string_record_parser_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   qsrp_record_checker result_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_if),
      .rsp_mon         (rsp_if),
      .fail_count      (fail_count),
      .pending         (pending),
      .results_checked (results_checked),
      .records_done    (records_done),
      .errors_seen     (errors_seen)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.in_byte = 8'd0;
      req_if.end_of_input = 1'b0;
      rsp_if.ready = 1'b0;
   end

   function automatic int gap_length();
      return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
   endfunction

   always @(negedge clock) begin
      logic take;
      if (stall_left > 0) begin
         stall_left--;
         take = 1'b0;
      end else if (stall_on && $urandom_range(0, 3) == 0) begin
         stall_left = gap_length() - 1;
         take = 1'b0;
      end else begin
         take = 1'b1;
      end
      rsp_if.ready <= take;
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("%0t: watchdog expired after %0d quiet cycles", $time, quiet);
      $display("Regression FAIL");
      $finish;
   end

   function automatic logic [7:0] blank_byte();
      return $urandom_range(0, 1) ? 8'($urandom_range(0, 32)) : 8'($urandom_range(128, 255));
   endfunction

   function automatic logic [7:0] id_char();
      logic [7:0] c;
      if ($urandom_range(0, 1)) begin
         c = $urandom_range(0, 1) ? 8'($urandom_range("A", "Z")) : 8'($urandom_range("a", "z"));
      end else begin
         do c = 8'($urandom_range(33, 127)); while (c == CH_COMMA || c == CH_QUOTE);
      end
      return c;
   endfunction

   function automatic logic [7:0] sep_char();
      case ($urandom_range(0, 2))
         0:       return CH_COMMA;
         1:       return CH_SPACE;
         default: return CH_TAB;
      endcase
   endfunction

   function automatic logic [7:0] text_char();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
      return c;
   endfunction

   function automatic logic [7:0] escape_char();
      case ($urandom_range(0, 4))
         0:       return CH_N;
         1:       return CH_R;
         2:       return CH_BSLASH;
         3:       return CH_QUOTE;
         default: return CH_T;
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] c, input logic last);
      int gap;
      gap = (idle_on && $urandom_range(0, 2) == 0) ? gap_length() : 0;
      repeat (gap) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
      end
      @(negedge clock);
      req_if.valid <= 1'b1;
      req_if.in_byte <= c;
      req_if.end_of_input <= last;
      do @(posedge clock); while (!req_if.ready);
      requests_sent++;
   endtask

   task automatic send_text(input string s, input bit last_at_end);
      for (int i = 0; i < s.len(); i++) begin
         send_byte(s[i], last_at_end && (i == s.len() - 1));
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic random_record();
      logic [7:0] rec_q[$];
      int         cut;
      int         pos;
      int         shape;
      bit         end_here;
      repeat ($urandom_range(0, 2)) rec_q = {rec_q, blank_byte()};
      rec_q = {rec_q, CH_HASH};
      repeat ($urandom_range(0, 6)) rec_q = {rec_q, id_char()};
      repeat ($urandom_range(0, 3)) rec_q = {rec_q, sep_char()};
      rec_q = {rec_q, CH_QUOTE};
      repeat ($urandom_range(0, 12)) begin
         if ($urandom_range(0, 4) == 0) begin
            rec_q = {rec_q, CH_BSLASH};
            rec_q = {rec_q, escape_char()};
         end else begin
            rec_q = {rec_q, text_char()};
         end
      end
      rec_q = {rec_q, CH_QUOTE};
      cut = rec_q.size();
      end_here = 1'b1;
      shape = $urandom_range(0, 19);
      if (shape < 2) begin
         cut = $urandom_range(1, rec_q.size());
      end else if (shape < 4) begin
         pos = $urandom_range(0, rec_q.size() - 1);
         rec_q[pos] = 8'($urandom_range(0, 255));
         cut = pos + 1 + $urandom_range(0, 2);
         if (cut > rec_q.size()) cut = rec_q.size();
      end else if (shape < 5) begin
         rec_q.delete();
         repeat ($urandom_range(1, 6)) rec_q = {rec_q, 8'($urandom_range(0, 255))};
         cut = rec_q.size();
      end else if (shape < 7) begin
         rec_q = {rec_q, blank_byte()};
         cut = rec_q.size();
      end else if (shape >= 8) begin
         end_here = 1'b0;
      end
      for (int i = 0; i < cut; i++) begin
         send_byte(rec_q[i], end_here && (i == cut - 1));
      end
   endtask

   initial begin
      int base;
      idle_on = 1'b1;
      stall_on = 1'b1;
      stall_left = 0;
      requests_sent = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_text("#Z\"a\\t\"", 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(CH_HASH, 1'b1);
      send_text("x", 1'b1);
      send_text("#,;", 1'b1);
      send_text("#;zz ", 1'b1);
      send_text("#\"\\q", 1'b1);
      send_text("#\"a", 1'b1);
      send_text("#\"\\", 1'b1);
      wait_drained();

      base = requests_sent;
      while (requests_sent - base < RANDOM_ITEMS) begin
         idle_on = $urandom_range(0, 3) != 0;
         stall_on = $urandom_range(0, 3) != 0;
         random_record();
         if ($urandom_range(0, 24) == 0) wait_drained();
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d requests: malformed and well-formed records, random gaps and stalls.",
               requests_sent);
      $display("Checked %0d results: %0d finished records and %0d errors.",
               results_checked, records_done, errors_seen);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
